@@ rtl/tcw_pkg.sv @@
// Package for the text console character writer.
// Holds default geometry, field widths, action codes, special characters, the reset
// attribute and the sequencer state type. No dependencies.
`default_nettype none

package tcw_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEF     = 80;
   localparam int SCREEN_ROWS_DEF = 25;
   localparam int TEXT_ROWS_DEF   = 24;

   // Field widths of the transactions.
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int POS_W    = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // Action codes carried on the request tuser.
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Special characters and the attribute after reset.
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h02;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCROLL,
      ST_PUT,
      ST_READ,
      ST_CLEAR,
      ST_FINISH
   } tcw_state_type;

endpackage

`default_nettype wire

@@ rtl/text_console_char_writer_top.sv @@
// Text console character writer: cursor logic and screen memory sequencer.
// Depends on tcw_pkg and tcw_ram.
//
// Usage:
// A request transaction carries the action on req_tuser and the character and
// cell index on req_tdata. Every request gives exactly one response transaction
// carrying the cursor position and the read cell on rsp_tdata and the cursor
// update flag on rsp_tuser. csr_wr_en with csr_wr_data sets the attribute byte
// stored with written and cleared cells; write it only while the block is idle.
// One request is worked on at a time; req_tready is high only when idle.
// A plain character write or newline passes through the put state to the response,
// a read through the read state, which takes the registered memory read data, and
// an unused action through the finish state before the response hand-off. A write
// that scrolls first copies every row below the top one row up in a sweep through
// the dual-port memory. Clear fills the screen one cell a cycle.
// The response sits in an output register, so the next request is accepted
// while the previous response waits. If rsp_tready stays low, the finished
// result waits in the sequencer and no further request is accepted.
// Reset homes the cursor and sets the attribute to 2; screen contents are
// undefined until cleared or written.
`default_nettype none

module text_console_char_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS     = COLUMNS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
   parameter int TEXT_ROWS   = TEXT_ROWS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration port.
   input  wire logic                csr_wr_en,
   input  wire logic [ATTR_W-1:0]   csr_wr_data,
   // Request channel.
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [23:0]         req_tdata,  // [7:0] character, [18:8] cell_index
   input  wire logic [ACTION_W-1:0] req_tuser,  // [1:0] action
   // Response channel.
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [31:0]              rsp_tdata,  // [10:0] cursor_position,
                                                // [18:11] read_char, [26:19] read_attr
   output logic                     rsp_tuser   // [0] cursor_valid
);

   localparam int CELL_COUNT = COLUMNS * SCREEN_ROWS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int COL_W      = $clog2(COLUMNS + 1);
   localparam int ROW_W      = $clog2(TEXT_ROWS + 2);
   localparam int LIN_W      = ROW_W + COL_W;

   // Request fields.
   logic [CHAR_W-1:0]  req_char;
   logic [INDEX_W-1:0] req_index;
   logic               req_fire;
   logic               req_in_range;

   assign req_char     = req_tdata[CHAR_W-1:0];
   assign req_index    = req_tdata[CHAR_W +: INDEX_W];
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_index) < 32'(CELL_COUNT);

   // Registers.
   tcw_state_type      state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ATTR_W-1:0]  attr_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               pend_valid_ff;
   logic               pend_read_ff;
   logic               mv_valid_ff, mv_valid_in;
   logic [AW-1:0]      mv_addr_ff, mv_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic               rsp_cv_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic [ATTR_W-1:0]  rsp_attr_ff;

   // Memory port signals.
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [CELL_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [CELL_W-1:0]  ram_rd_data;

   // Shared combinational values.
   logic [COL_W-1:0]   wrap_col;
   logic [ROW_W-1:0]   wrap_row;
   logic               scroll_need;
   logic [LIN_W-1:0]   lin_cur;
   logic [LIN_W-1:0]   lin_nxt;
   logic               put_in_range;
   logic               slot_free;
   logic               emit;
   logic [CNT_W-1:0]   cnt_src;

   // Cursor after the column wrap, and whether that row needs a scroll.
   always_comb begin
      if (col_ff >= COL_W'(COLUMNS)) begin
         wrap_col = '0;
         wrap_row = row_ff + ROW_W'(1);
      end else begin
         wrap_col = col_ff;
         wrap_row = row_ff;
      end
      scroll_need = wrap_row >= ROW_W'(TEXT_ROWS);
   end

   // Linear cell numbers of the current and next cursor.
   assign lin_cur      = LIN_W'(row_ff) * LIN_W'(COLUMNS) + LIN_W'(col_ff);
   assign lin_nxt      = LIN_W'(row_in) * LIN_W'(COLUMNS) + LIN_W'(col_in);
   assign put_in_range = 32'(lin_cur) < 32'(CELL_COUNT);
   assign cnt_src      = cnt_ff - CNT_W'(COLUMNS);

   // The output register can take a result this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit      = slot_free &&
                      (state_ff == ST_PUT || state_ff == ST_READ || state_ff == ST_FINISH);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  ACT_WRITE: state_in = scroll_need ? ST_SCROLL : ST_PUT;
                  ACT_READ:  state_in = ST_READ;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCROLL: begin
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               state_in = ST_PUT;
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_PUT, ST_READ, ST_FINISH: begin
            state_in = emit ? ST_IDLE : ST_FINISH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Cursor, sweep counter and memory controls.
   always_comb begin
      req_tready  = state_ff == ST_IDLE;
      col_in      = col_ff;
      row_in      = row_ff;
      cnt_in      = cnt_ff;
      mv_valid_in = 1'b0;
      mv_addr_in  = cnt_src[AW-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(32'(req_index));
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(lin_cur);
      ram_wr_data = {attr_ff, char_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  ACT_WRITE: begin
                     col_in = wrap_col;
                     cnt_in = CNT_W'(COLUMNS);
                     row_in = scroll_need ? ROW_W'(TEXT_ROWS - 1) : wrap_row;
                  end
                  ACT_READ: begin
                     ram_rd_en = req_in_range;
                  end
                  ACT_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                     cnt_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCROLL: begin
            // Read one row ahead, write the entry back one row higher next cycle.
            if (cnt_ff != CNT_W'(CELL_COUNT)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff[AW-1:0];
               mv_valid_in = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[AW-1:0];
            ram_wr_data = {attr_ff, SPACE_CHAR};
            cnt_in      = cnt_ff + CNT_W'(1);
         end
         ST_PUT: begin
            if (char_ff == NEWLINE_CHAR) begin
               row_in = row_ff + ROW_W'(1);
               col_in = '0;
            end else begin
               ram_wr_en = put_in_range;
               col_in    = col_ff + COL_W'(1);
            end
         end
         default: ;
      endcase
      // The pending scroll move owns the write port.
      if (mv_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = mv_addr_ff;
         ram_wr_data = ram_rd_data;
      end
   end

   // Response register next value.
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         mv_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         mv_valid_ff  <= mv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // Working registers of the transaction in progress.
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      mv_addr_ff <= mv_addr_in;
      if (req_fire) begin
         char_ff       <= req_char;
         pend_valid_ff <= req_tuser == ACT_WRITE && req_char != NEWLINE_CHAR;
         pend_read_ff  <= req_tuser == ACT_READ && req_in_range;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pos_ff  <= POS_W'(32'(lin_nxt));
         rsp_cv_ff   <= pend_valid_ff;
         rsp_char_ff <= pend_read_ff ? ram_rd_data[CHAR_W-1:0] : '0;
         rsp_attr_ff <= pend_read_ff ? ram_rd_data[CHAR_W +: ATTR_W] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_attr_ff, rsp_char_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_cv_ff;

   // Screen memory.
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef ASSERT_OFF
   // The memory is never written while the sequencer waits for a request.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_wr_en)
      else $error("screen memory written while idle");

   // Scroll moves only happen during the scroll sweep.
   a_move_in_scroll: assert property (@(posedge clock) disable iff (reset)
      mv_valid_ff |-> state_ff == ST_SCROLL)
      else $error("scroll move outside the scroll sweep");

   // A character is placed only on a text row.
   a_put_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT |-> row_ff < ROW_W'(TEXT_ROWS))
      else $error("character placed below the text rows");

   // The column never runs more than one past the last column.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(COLUMNS))
      else $error("cursor column out of range");

   // An accepted read reaches the read state in the next cycle.
   a_read_path: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == ACT_READ |=> state_ff == ST_READ)
      else $error("read transaction did not reach the read state");
`endif

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port and one read port.
// Read data is registered and holds while no read is requested. No dependencies.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for text_console_char_writer_top.
// Depends on tcw_pkg and the console writer RTL; predicts every response with
// its own screen and cursor model and checks responses in order.
module tb_top
   import tcw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS        = COLUMNS_DEF;
   localparam int TEXT_ROWS   = TEXT_ROWS_DEF;
   localparam int CELLS       = COLUMNS_DEF * SCREEN_ROWS_DEF;
   localparam int INDEX_MAX   = (1 << INDEX_W) - 1;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int REPORT_MAX  = 10;

   // Action code that the block ignores.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   character;
      logic [INDEX_W-1:0]  cell_index;
   } console_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic              cursor_valid;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attr;
   } console_rsp_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // Block inputs, all known from time zero.
   logic              csr_wr_en   = 1'b0;
   logic [ATTR_W-1:0] csr_wr_data = '0;
   logic              req_tvalid  = 1'b0;
   logic [23:0]       req_tdata   = '0;  // [7:0] character, [18:8] cell_index
   logic [ACTION_W-1:0] req_tuser = '0;  // [1:0] action
   logic              rsp_tready  = 1'b0;

   // Block outputs.
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;  // [10:0] cursor_position, [18:11] read_char, [26:19] read_attr
   logic        rsp_tuser;  // [0] cursor_valid

   text_console_char_writer_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // Console model state; the cursor starts at home as after reset.
   logic [CELL_W-1:0] screen_model [CELLS];
   int                model_row = 0;
   int                model_col = 0;
   logic [ATTR_W-1:0] model_attr;

   // Traffic between the stimulus, the driver and the monitor.
   console_req_type queued_requests [$];
   console_rsp_type due_responses [$];
   int           mismatch_count;
   int           responses_checked;
   int           char_count, newline_count, scroll_count;
   int           read_count, clear_count, ignored_count, attr_settings;
   int           cycle_count;

   // Advance the console model by one request and compute its response.
   task automatic console_step(input console_req_type rq, output console_rsp_type rs);
      int idx;
      rs = '0;
      case (rq.action)
         ACT_WRITE: begin
            if (model_col >= COLS) begin
               model_col = 0;
               model_row++;
            end
            // Scrolling moves rows 1 and below up; the bottom row keeps its text.
            if (model_row >= TEXT_ROWS) begin
               for (int k = 0; k < CELLS - COLS; k++)
                  screen_model[k] = screen_model[k + COLS];
               model_row = TEXT_ROWS - 1;
               scroll_count++;
            end
            if (rq.character == NEWLINE_CHAR) begin
               model_row++;
               model_col = 0;
               newline_count++;
            end else begin
               idx = model_row * COLS + model_col;
               if (idx < CELLS)
                  screen_model[idx] = {model_attr, rq.character};
               model_col++;
               rs.cursor_valid = 1'b1;
               char_count++;
            end
         end
         ACT_READ: begin
            if (rq.cell_index < CELLS)
               {rs.read_attr, rs.read_char} = screen_model[rq.cell_index];
            read_count++;
         end
         ACT_CLEAR: begin
            for (int k = 0; k < CELLS; k++)
               screen_model[k] = {model_attr, SPACE_CHAR};
            model_row = 0;
            model_col = 0;
            clear_count++;
         end
         default: begin
            ignored_count++;
         end
      endcase
      rs.cursor_position = POS_W'(model_row * COLS + model_col);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   console_req_type in_flight;
   int           burst_left;
   int           gap_left;

   always @(posedge clock) begin : request_driver
      console_rsp_type predicted;
      logic         next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            console_step(in_flight, predicted);
            due_responses.push_back(predicted);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_requests.size() > 0) begin
               in_flight = queued_requests.pop_front();
               req_tdata <= {5'b0, in_flight.cell_index, in_flight.character};
               req_tuser <= in_flight.action;
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Response monitor and receiver. Ready follows a rotating pattern, with
   // two long hold-offs so the block backs up and stalls its request side.
   logic [15:0] ready_pattern;
   int          pattern_age;
   int          hold_left;

   always @(posedge clock) begin : response_monitor
      console_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         pattern_age = 0;
         hold_left   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_checked++;
            if (due_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("Unexpected response transaction: tdata %h tuser %b",
                           rsp_tdata, rsp_tuser);
            end else begin
               want = due_responses.pop_front();
               if (rsp_tdata[10:0] !== want.cursor_position ||
                   rsp_tuser !== want.cursor_valid ||
                   rsp_tdata[18:11] !== want.read_char ||
                   rsp_tdata[26:19] !== want.read_attr) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"Response %0d: expected pos %0d valid %b char %h attr %h,",
                               " got pos %0d valid %b char %h attr %h"},
                              responses_checked, want.cursor_position,
                              want.cursor_valid, want.read_char, want.read_attr,
                              rsp_tdata[10:0], rsp_tuser, rsp_tdata[18:11],
                              rsp_tdata[26:19]);
               end
            end
            if (responses_checked == 150 || responses_checked == 520)
               hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
               pattern_age   = 64;
            end
            pattern_age--;
            rsp_tready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_responses.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Queue one request; ignored actions do not count toward the item total.
   int counted_items;

   task automatic add_request(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
      console_req_type rq;
      rq.action     = act;
      rq.character  = ch;
      rq.cell_index = idx;
      queued_requests.push_back(rq);
      if (act != ACT_UNUSED)
         counted_items++;
   endtask

   // Read addresses: mostly on screen, some on the top or bottom row, some past the end.
   function automatic logic [INDEX_W-1:0] pick_cell();
      case ($urandom_range(0, 9))
         0, 1:    return INDEX_W'($urandom_range(CELLS, INDEX_MAX));
         2, 3:    return INDEX_W'($urandom_range(CELLS - COLS, CELLS - 1));
         4:       return INDEX_W'($urandom_range(0, COLS - 1));
         default: return INDEX_W'($urandom_range(0, CELLS - 1));
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] printable_char();
      logic [CHAR_W-1:0] ch;
      do
         ch = CHAR_W'($urandom);
      while (ch == NEWLINE_CHAR);
      return ch;
   endfunction

   // Random traffic: text lines, runs of newlines, reads, clears and noise.
   task automatic add_random_traffic(input int n);
      int kind;
      int len;
      counted_items = 0;
      while (counted_items < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 85) : $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
               add_request(ACT_WRITE, printable_char(), INDEX_W'($urandom));
               if ($urandom_range(0, 11) == 0)
                  add_request(ACT_READ, CHAR_W'($urandom), pick_cell());
            end
            if ($urandom_range(0, 5) != 0)
               add_request(ACT_WRITE, NEWLINE_CHAR, INDEX_W'($urandom));
         end else if (kind < 50) begin
            len = $urandom_range(2, 8);
            for (int i = 0; i < len; i++)
               add_request(ACT_WRITE, NEWLINE_CHAR, INDEX_W'($urandom));
         end else if (kind < 70) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               add_request(ACT_READ, CHAR_W'($urandom), pick_cell());
         end else if (kind < 75) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
               add_request(ACT_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
         end else if (kind < 78) begin
            add_request(ACT_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 1) == 0)
                  add_request(ACT_WRITE, CHAR_W'($urandom), INDEX_W'($urandom));
               else
                  add_request(ACT_READ, CHAR_W'($urandom), pick_cell());
            end
         end
      end
   endtask

   // The sender pauses here until every queued request has been answered.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || due_responses.size() != 0);
   endtask

   // Attribute register writes happen only while the block is idle.
   task automatic set_attribute(input logic [ATTR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      model_attr = value;
      attr_settings++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus sequence.
   initial begin
      model_attr = ATTR_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: clear first so no cell is read before it is defined, then
      // the field extremes, newline, reads past the end and the unused action.
      add_request(ACT_CLEAR, 8'hFF, INDEX_W'(INDEX_MAX));
      add_request(ACT_READ,  8'h00, 11'd0);
      add_request(ACT_WRITE, 8'h41, 11'd0);
      add_request(ACT_WRITE, 8'h00, INDEX_W'(INDEX_MAX));
      add_request(ACT_WRITE, 8'hFF, 11'd0);
      add_request(ACT_WRITE, NEWLINE_CHAR, 11'd0);
      add_request(ACT_WRITE, 8'h7F, 11'd5);
      add_request(ACT_READ,  8'hFF, 11'd0);
      add_request(ACT_READ,  8'h00, 11'd1);
      add_request(ACT_READ,  8'h00, 11'd2);
      add_request(ACT_READ,  8'h00, 11'd80);
      add_request(ACT_READ,  8'h00, 11'd1999);
      add_request(ACT_READ,  8'h00, 11'd2000);
      add_request(ACT_READ,  8'hFF, INDEX_W'(INDEX_MAX));
      add_request(ACT_UNUSED, 8'hFF, INDEX_W'(INDEX_MAX));
      add_request(ACT_UNUSED, 8'h00, 11'd0);
      add_request(ACT_WRITE, NEWLINE_CHAR, 11'd0);
      add_request(ACT_WRITE, NEWLINE_CHAR, 11'd0);
      add_request(ACT_READ,  8'h00, 11'd81);
      add_request(ACT_CLEAR, 8'h00, 11'd0);
      add_request(ACT_READ,  8'h00, 11'd0);
      wait_drained();

      // Random phases under different attribute settings, extremes first.
      set_attribute(8'hFF);
      add_random_traffic(200);
      wait_drained();
      set_attribute(8'h00);
      add_random_traffic(200);
      wait_drained();
      set_attribute(ATTR_W'($urandom));
      add_random_traffic(200);
      wait_drained();
      set_attribute(ATTR_W'($urandom));
      add_random_traffic(200);
      wait_drained();

      // Let any stray response show up before the verdict.
      repeat (50) @(posedge clock);
      if (due_responses.size() != 0)
         mismatch_count += due_responses.size();

      $display("Run covered %0d character writes, %0d newlines, %0d scrolls, %0d reads,",
               char_count, newline_count, scroll_count, read_count);
      $display("%0d clears and %0d ignored requests over %0d attribute settings.",
               clear_count, ignored_count, attr_settings + 1);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
